@@ src/rtp_pkg.sv @@
// ----------------------------------------------------------------------------
// rtp_pkg
// Types and constants shared by the report trigger policy block.
// ----------------------------------------------------------------------------
package rtp_pkg;

	localparam int IntervalMinDefault = 10;
	localparam int IntervalMaxDefault = 250;

	localparam logic [15:0] IntervalReset = 16'd60;
	localparam logic [7:0]  SecSat        = 8'd250;
	localparam logic [7:0]  RunStatusSecs = 8'd5;
	localparam logic [6:0]  MoveStep      = 7'd10;
	localparam logic [6:0]  FullOpen      = 7'd100;

	typedef struct packed {
		logic [6:0] opening_pct;
		logic       motor_running;
	} tick_t;

	typedef struct packed {
		logic send_full;
		logic send_status;
	} report_t;

endpackage

@@ src/report_trigger_policy_unit.sv @@
// ----------------------------------------------------------------------------
// report_trigger_policy_unit
// Per-tick report trigger: full, status-only or no report for each tick.
//
//   channel  dir  handshake        payload
//   tick     in   valid / stall    rtp_pkg::tick_t
//   report   out  valid / stall    rtp_pkg::report_t
//   cfg      in   valid / ready    upload_interval, 16 bit
//
// One tick per cycle sustained while report is not stalled; a tick beat loads
// the input register, whose report loads the result register on advance.
// Reset clears the trigger state, sets the first-report flag, interval 60.
// A stalled report holds; the input register still fills, then tick stalls.
// cfg is always ready.
// ----------------------------------------------------------------------------
module report_trigger_policy_unit #(
	parameter int INTERVAL_MIN = rtp_pkg::IntervalMinDefault,
	parameter int INTERVAL_MAX = rtp_pkg::IntervalMaxDefault
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             tick_valid,
	output logic             tick_stall,
	input  rtp_pkg::tick_t   tick,
	output logic             report_valid,
	input  logic             report_stall,
	output rtp_pkg::report_t report,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [15:0]      cfg_data
);

	logic             valid_s1;
	rtp_pkg::tick_t   tick_s1;
	logic             out_valid_q;
	rtp_pkg::report_t out_q;
	logic [15:0]      interval_q;
	logic             advance;
	rtp_pkg::report_t res;

	assign advance      = valid_s1 && (!out_valid_q || !report_stall);
	assign tick_stall   = valid_s1 && !advance;
	assign report_valid = out_valid_q;
	assign report       = out_q;
	assign cfg_ready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= rtp_pkg::IntervalReset;
		end else if (cfg_valid && cfg_ready) begin
			interval_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!tick_stall) begin
			valid_s1 <= tick_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_valid && !tick_stall) begin
			tick_s1 <= tick;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!report_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	rtp_core #(
		.INTERVAL_MIN(INTERVAL_MIN),
		.INTERVAL_MAX(INTERVAL_MAX)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (advance),
		.tick           (tick_s1),
		.upload_interval(interval_q),
		.res            (res)
	);

endmodule

@@ src/rtp_core.sv @@
// ----------------------------------------------------------------------------
// rtp_core
// Trigger state and per-tick decision; state advances on each enabled beat.
// ----------------------------------------------------------------------------
module rtp_core #(
	parameter int INTERVAL_MIN = rtp_pkg::IntervalMinDefault,
	parameter int INTERVAL_MAX = rtp_pkg::IntervalMaxDefault
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  rtp_pkg::tick_t   tick,
	input  logic [15:0]      upload_interval,
	output rtp_pkg::report_t res
);

	localparam logic [15:0] Min16 = 16'(INTERVAL_MIN);
	localparam logic [15:0] Max16 = 16'(INTERVAL_MAX);

	logic [7:0] full_seconds_q;
	logic [7:0] status_seconds_q;
	logic [6:0] last_opening_q;
	logic       last_valid_q;
	logic       was_running_q;
	logic       first_due_q;

	logic [15:0] interval;
	logic [7:0]  full_inc;
	logic [7:0]  status_inc;
	logic [6:0]  open;
	logic [6:0]  delta;
	logic        running;
	logic        big_move;
	logic        need;
	logic        fire_full;

	always_comb begin
		if (upload_interval < Min16) begin
			interval = Min16;
		end else if (upload_interval > Max16) begin
			interval = Max16;
		end else begin
			interval = upload_interval;
		end
	end

	always_comb begin
		open       = (tick.opening_pct > rtp_pkg::FullOpen) ? rtp_pkg::FullOpen
		                                                   : tick.opening_pct;
		running    = tick.motor_running;
		full_inc   = (full_seconds_q < rtp_pkg::SecSat) ? full_seconds_q + 8'd1
		                                                : full_seconds_q;
		status_inc = (status_seconds_q < rtp_pkg::SecSat) ? status_seconds_q + 8'd1
		                                                  : status_seconds_q;
		delta      = (open >= last_opening_q) ? open - last_opening_q
		                                      : last_opening_q - open;
		big_move   = delta >= rtp_pkg::MoveStep;

		if (running) begin
			need = !was_running_q || (last_valid_q && big_move) ||
			       (status_inc >= rtp_pkg::RunStatusSecs);
		end else if (was_running_q) begin
			need = 1'b1;
		end else begin
			need = last_valid_q && (open != last_opening_q) &&
			       ((open == 7'd0) || (open >= rtp_pkg::FullOpen) || big_move);
		end

		fire_full       = first_due_q || ({8'd0, full_inc} >= interval);
		res.send_full   = fire_full;
		res.send_status = !fire_full && need;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_seconds_q   <= 8'd0;
			status_seconds_q <= 8'd0;
			last_opening_q   <= 7'd0;
			last_valid_q     <= 1'b0;
			was_running_q    <= 1'b0;
			first_due_q      <= 1'b1;
		end else if (en) begin
			was_running_q <= running;
			if (fire_full) begin
				first_due_q      <= 1'b0;
				full_seconds_q   <= 8'd0;
				status_seconds_q <= 8'd0;
				last_opening_q   <= open;
				last_valid_q     <= 1'b1;
			end else begin
				full_seconds_q <= full_inc;
				if (need) begin
					status_seconds_q <= 8'd0;
					last_opening_q   <= open;
					last_valid_q     <= 1'b1;
				end else begin
					status_seconds_q <= status_inc;
				end
			end
		end
	end

	a_first_tick_full: assert property (@(posedge clk) disable iff (!arst_n)
		en && first_due_q |-> res.send_full)
		else $error("first tick did not fire a full report");

	a_full_clears: assert property (@(posedge clk) disable iff (!arst_n)
		en && res.send_full |=> full_seconds_q == 8'd0 && status_seconds_q == 8'd0 &&
		last_valid_q && !first_due_q)
		else $error("full report did not clear counters");

	a_status_clears: assert property (@(posedge clk) disable iff (!arst_n)
		en && res.send_status |=> status_seconds_q == 8'd0 && last_valid_q)
		else $error("status report did not clear status counter");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		full_seconds_q <= rtp_pkg::SecSat && status_seconds_q <= rtp_pkg::SecSat)
		else $error("seconds counter beyond saturation");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for report_trigger_policy_unit. A driver process sends
// ticks from a queue and forecasts the report each accepted tick must give.
// A monitor process stalls at random and compares every report beat with the
// oldest forecast. A directed opening is followed by phases of random vent
// traffic under different upload intervals and idle and stall patterns.
// ----------------------------------------------------------------------------
module testbench;

	logic             clk          = 1'b0;
	logic             arst_n       = 1'b0;
	logic             tick_valid   = 1'b0;
	logic             tick_stall;
	rtp_pkg::tick_t   tick         = '0;
	logic             report_valid;
	logic             report_stall = 1'b0;
	rtp_pkg::report_t report;
	logic             cfg_valid    = 1'b0;
	logic             cfg_ready;
	logic [15:0]      cfg_data     = '0;

	report_trigger_policy_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick_valid   (tick_valid),
		.tick_stall   (tick_stall),
		.tick         (tick),
		.report_valid (report_valid),
		.report_stall (report_stall),
		.report       (report),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	rtp_pkg::tick_t   pending_ticks[$];
	rtp_pkg::report_t predicted_reports[$];
	int          ticks_unsent    = 0;
	int          sender_idle_pct = 0;
	int          stall_pct       = 0;
	int          fail_count      = 0;
	bit          hold_req        = 1'b0;
	bit          hold_taken      = 1'b0;
	int          hold_left       = 0;

	logic [15:0] interval_reg = rtp_pkg::IntervalReset;
	logic [7:0]  full_secs    = '0;
	logic [7:0]  status_secs  = '0;
	logic [6:0]  last_open    = '0;
	logic        last_open_ok = 1'b0;
	logic        was_run      = 1'b0;
	logic        first_due    = 1'b1;

	int          vent_pos = 50;
	int          vent_dir = 1;
	logic        vent_run = 1'b0;

	always #1 clk = ~clk;

	initial begin
		#1_000_000;
		$display("report_trigger_policy_unit test failed");
		$finish;
	end

	task forecast_report(input rtp_pkg::tick_t t);
		logic [6:0]       open;
		logic [6:0]       delta;
		logic [15:0]      limit;
		logic             need;
		rtp_pkg::report_t r;
		open = (t.opening_pct > rtp_pkg::FullOpen) ? rtp_pkg::FullOpen : t.opening_pct;
		if (interval_reg < rtp_pkg::IntervalMinDefault)
			limit = 16'(rtp_pkg::IntervalMinDefault);
		else if (interval_reg > rtp_pkg::IntervalMaxDefault)
			limit = 16'(rtp_pkg::IntervalMaxDefault);
		else
			limit = interval_reg;
		if (full_secs < rtp_pkg::SecSat)
			full_secs = full_secs + 8'd1;
		if (status_secs < rtp_pkg::SecSat)
			status_secs = status_secs + 8'd1;
		delta = (open >= last_open) ? open - last_open : last_open - open;
		need = 1'b0;
		if (t.motor_running) begin
			if (!was_run)
				need = 1'b1;
			else if (last_open_ok && delta >= rtp_pkg::MoveStep)
				need = 1'b1;
			else if (status_secs >= rtp_pkg::RunStatusSecs)
				need = 1'b1;
		end else if (was_run) begin
			need = 1'b1;
		end else if (last_open_ok && open != last_open &&
				(open == 7'd0 || open >= rtp_pkg::FullOpen ||
				delta >= rtp_pkg::MoveStep)) begin
			need = 1'b1;
		end
		if (first_due || {8'd0, full_secs} >= limit) begin
			first_due    = 1'b0;
			full_secs    = '0;
			status_secs  = '0;
			last_open    = open;
			last_open_ok = 1'b1;
			r.send_full   = 1'b1;
			r.send_status = 1'b0;
		end else begin
			if (need) begin
				status_secs  = '0;
				last_open    = open;
				last_open_ok = 1'b1;
			end
			r.send_full   = 1'b0;
			r.send_status = need;
		end
		was_run = t.motor_running;
		predicted_reports.push_back(r);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (tick_valid && !tick_stall) begin
				forecast_report(tick);
				ticks_unsent--;
			end
			if (!tick_valid || !tick_stall) begin
				if (pending_ticks.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					tick       <= pending_ticks.pop_front();
					tick_valid <= 1'b1;
				end else begin
					tick_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		rtp_pkg::report_t want;
		if (arst_n) begin
			if (report_valid && !report_stall) begin
				if (predicted_reports.size() == 0) begin
					$error("report beat with no tick outstanding: %b", report);
					fail_count++;
				end else begin
					want = predicted_reports.pop_front();
					if (report.send_full !== want.send_full) begin
						$error("send_full expected %b actual %b",
							want.send_full, report.send_full);
						fail_count++;
					end
					if (report.send_status !== want.send_status) begin
						$error("send_status expected %b actual %b",
							want.send_status, report.send_status);
						fail_count++;
					end
				end
			end
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left  = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				report_stall <= 1'b1;
			end else begin
				report_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	task push_tick(input logic [6:0] open, input logic run);
		rtp_pkg::tick_t t;
		t.opening_pct   = open;
		t.motor_running = run;
		pending_ticks.push_back(t);
		ticks_unsent++;
	endtask

	task make_tick(output rtp_pkg::tick_t t);
		int r;
		int step;
		r = $urandom_range(99);
		if (r < 5) begin
			t.opening_pct   = 7'($urandom);
			t.motor_running = 1'($urandom);
		end else begin
			if (r < 12)
				vent_run = ~vent_run;
			if (r >= 12 && r < 17) begin
				vent_pos = $urandom_range(100);
			end else if (vent_run) begin
				step     = $urandom_range(4);
				vent_pos = vent_pos + vent_dir * step;
			end else if (r < 24) begin
				step     = $urandom_range(2);
				vent_pos = vent_pos + step - 1;
			end
			if (vent_pos <= 0) begin
				vent_pos = 0;
				vent_dir = 1;
			end
			if (vent_pos >= 100) begin
				vent_pos = 100;
				vent_dir = -1;
			end
			t.opening_pct = 7'(vent_pos);
			if ($urandom_range(99) < 5)
				t.opening_pct = 7'($urandom_range(127, 101));
			t.motor_running = vent_run;
		end
	endtask

	task wait_drained();
		do
			@(posedge clk);
		while (ticks_unsent != 0 || predicted_reports.size() != 0);
	endtask

	task write_interval(input logic [15:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		interval_reg = value;
		cfg_valid <= 1'b0;
	endtask

	task run_phase(input logic [15:0] value, input int idle, input int stall, input int n,
			input bit long_hold);
		rtp_pkg::tick_t t;
		write_interval(value);
		sender_idle_pct = idle;
		stall_pct       = stall;
		if (long_hold)
			hold_req = 1'b1;
		for (int k = 0; k < n; k++) begin
			make_tick(t);
			pending_ticks.push_back(t);
			ticks_unsent++;
		end
		wait_drained();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// first tick after reset, then idle and running triggers at interval 60
		push_tick(7'd50, 1'b0);
		push_tick(7'd50, 1'b0);
		push_tick(7'd55, 1'b0);
		push_tick(7'd60, 1'b0);
		push_tick(7'd0, 1'b0);
		push_tick(7'd0, 1'b0);
		push_tick(7'd100, 1'b0);
		push_tick(7'd127, 1'b0);
		push_tick(7'd101, 1'b1);
		push_tick(7'd95, 1'b1);
		push_tick(7'd92, 1'b1);
		push_tick(7'd93, 1'b1);
		push_tick(7'd94, 1'b1);
		push_tick(7'd94, 1'b1);
		push_tick(7'd84, 1'b1);
		push_tick(7'd84, 1'b0);
		push_tick(7'd1, 1'b0);
		push_tick(7'd0, 1'b0);
		push_tick(7'd127, 1'b1);
		push_tick(7'd0, 1'b1);
		push_tick(7'd64, 1'b0);
		push_tick(7'd63, 1'b0);
		wait_drained();

		run_phase(16'd0, 0, 0, 90, 1'b0);
		run_phase(16'hFFFF, 54, 0, 260, 1'b0);
		run_phase(16'd9, 0, 54, 90, 1'b1);
		run_phase(16'd10, 31, 31, 90, 1'b0);
		run_phase(16'($urandom_range(249, 11)), 0, 0, 60, 1'b0);
		run_phase(16'd1, 31, 31, 40, 1'b0);
		run_phase(16'd250, 0, 0, 20, 1'b0);

		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("report_trigger_policy_unit test passed");
		else
			$display("report_trigger_policy_unit test failed");
		$finish;
	end

endmodule

@@ files.f @@
src/rtp_pkg.sv
src/rtp_core.sv
src/report_trigger_policy_unit.sv
tb/testbench.sv
